// ----- rtl/core/fcst_pkg.sv -----
// Shared types, constants and the microcode program of the fine code sweep tracker.
package fcst_pkg;

  localparam int FRAMES_W  = 8;
  localparam int PERIOD_W  = 10;
  localparam int MIN_W     = 12;
  localparam int SPAN_W    = 3;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SUCCESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SPAN    = 2'd2;

  localparam logic [PERIOD_W-1:0] CALIB_PERIOD_RESET = 10'd20;
  localparam logic [MIN_W-1:0]    MIN_SUCCESS_RESET  = 12'd10;
  localparam logic [SPAN_W-1:0]   HALF_SPAN_RESET    = 3'd2;
  localparam int                  RX_CODE_RESET      = 15;
  localparam int                  TX_CODE_RESET      = 23;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_ROUTE    = 4'd1;
  localparam step_t S_COUNT    = 4'd2;
  localparam step_t S_BEGIN    = 4'd3;
  localparam step_t S_ACCUM    = 4'd4;
  localparam step_t S_STEP     = 4'd5;
  localparam step_t S_END      = 4'd6;
  localparam step_t S_DIV_LOAD = 4'd7;
  localparam step_t S_DIV_STEP = 4'd8;
  localparam step_t S_APPLY    = 4'd9;
  localparam step_t S_RESTORE  = 4'd10;
  localparam step_t S_EMIT     = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_COUNT,
    OP_BEGIN,
    OP_ACCUM,
    OP_STEP,
    OP_END,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_APPLY,
    OP_RESTORE,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_FIRE,
    C_SWEEP,
    C_NO_TRIG,
    C_MORE,
    C_REJECT,
    C_DIV_MORE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  wait_here;  // stay on this step while the condition is false
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic sweep;
    logic no_trig;
    logic more;
    logic reject;
    logic div_more;
    logic out_free;
  } cond_flags_t;

  function automatic ctrl_word_t ucode_rom(step_t pc);
    ctrl_word_t w;
    case (pc)
      S_IDLE:     w = '{op: OP_LOAD,     cond: C_IN_FIRE,  wait_here: 1'b1, target: S_ROUTE};
      S_ROUTE:    w = '{op: OP_NOP,      cond: C_SWEEP,    wait_here: 1'b0, target: S_ACCUM};
      S_COUNT:    w = '{op: OP_COUNT,    cond: C_NO_TRIG,  wait_here: 1'b0, target: S_EMIT};
      S_BEGIN:    w = '{op: OP_BEGIN,    cond: C_ALWAYS,   wait_here: 1'b0, target: S_EMIT};
      S_ACCUM:    w = '{op: OP_ACCUM,    cond: C_NEVER,    wait_here: 1'b0, target: S_IDLE};
      S_STEP:     w = '{op: OP_STEP,     cond: C_MORE,     wait_here: 1'b0, target: S_EMIT};
      S_END:      w = '{op: OP_END,      cond: C_REJECT,   wait_here: 1'b0, target: S_RESTORE};
      S_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: C_NEVER,    wait_here: 1'b0, target: S_IDLE};
      S_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, wait_here: 1'b0, target: S_DIV_STEP};
      S_APPLY:    w = '{op: OP_APPLY,    cond: C_ALWAYS,   wait_here: 1'b0, target: S_EMIT};
      S_RESTORE:  w = '{op: OP_RESTORE,  cond: C_NEVER,    wait_here: 1'b0, target: S_IDLE};
      S_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_FREE, wait_here: 1'b1, target: S_IDLE};
      default:    w = '{op: OP_NOP,      cond: C_ALWAYS,   wait_here: 1'b0, target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/fcst_seq.sv -----
// Microcode sequencer: step counter, program table and jump condition select.
module fcst_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  fcst_pkg::cond_flags_t flags,
  output fcst_pkg::ctrl_word_t  word
);

  fcst_pkg::step_t pc;
  fcst_pkg::step_t pc_next;
  logic            take;

  assign word = fcst_pkg::ucode_rom(pc);

  always_comb begin
    case (word.cond)
      fcst_pkg::C_NEVER:    take = 1'b0;
      fcst_pkg::C_ALWAYS:   take = 1'b1;
      fcst_pkg::C_IN_FIRE:  take = flags.in_fire;
      fcst_pkg::C_SWEEP:    take = flags.sweep;
      fcst_pkg::C_NO_TRIG:  take = flags.no_trig;
      fcst_pkg::C_MORE:     take = flags.more;
      fcst_pkg::C_REJECT:   take = flags.reject;
      fcst_pkg::C_DIV_MORE: take = flags.div_more;
      fcst_pkg::C_OUT_FREE: take = flags.out_free;
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_next = word.target;
    end else if (word.wait_here) begin
      pc_next = pc;
    end else begin
      pc_next = pc + fcst_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= fcst_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- rtl/core/fine_code_sweep_tracker_unit.sv -----
// Top level of the fine code sweep tracker: datapath, config registers and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready  | frames_received
//   out     | output    | out_valid / out_ready| rx_code_next, tx_code, sweeping,
//           |           |                      | sweep_done, sweep_accepted
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// A normal window report runs load, route, count and emit; one that starts a sweep adds
// begin; one inside a sweep runs accumulate and step, not count. The last sweep window
// restores the code if rejected, else the serial divider finds the mean, one quotient bit
// a cycle. Reset is synchronous; it restores the config defaults and the start codes.
// A result that waits on out_ready does not block the next transfer in; the sequencer
// holds on its emit step only when the result register is still occupied.
module fine_code_sweep_tracker_unit #(
  parameter int CODE_MAX = 31
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fcst_pkg::FRAMES_W-1:0]    frames_received,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [$clog2(CODE_MAX+1)-1:0]    rx_code_next,
  output logic [$clog2(CODE_MAX+1)-1:0]    tx_code,
  output logic                             sweeping,
  output logic                             sweep_done,
  output logic                             sweep_accepted,
  input  logic                             cfg_write,
  input  logic [fcst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcst_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CODE_W  = $clog2(CODE_MAX + 1);
  // A sweep visits at most CODE_MAX+1 codes, which bounds the accumulators.
  localparam int TOT_W   = fcst_pkg::FRAMES_W + CODE_W;
  localparam int SUM_W   = TOT_W + CODE_W;
  localparam int CMP_W   = (TOT_W > fcst_pkg::MIN_W) ? TOT_W : fcst_pkg::MIN_W;
  localparam int CNT_W   = $clog2(CODE_W);
  localparam int PROD_W  = fcst_pkg::FRAMES_W + CODE_W;
  localparam int DIFF_W  = CODE_W + 2;
  localparam logic [CODE_W-1:0] CODE_TOP = CODE_W'(CODE_MAX);
  localparam logic [CODE_W-1:0] RX_INIT  =
    CODE_W'((fcst_pkg::RX_CODE_RESET > CODE_MAX) ? CODE_MAX : fcst_pkg::RX_CODE_RESET);
  localparam logic [CODE_W-1:0] TX_INIT  =
    CODE_W'((fcst_pkg::TX_CODE_RESET > CODE_MAX) ? CODE_MAX : fcst_pkg::TX_CODE_RESET);

  // Configuration registers
  logic [fcst_pkg::PERIOD_W-1:0] calib_period;
  logic [fcst_pkg::MIN_W-1:0]    min_success;
  logic [fcst_pkg::SPAN_W-1:0]   half_span;

  // Tracking state
  logic [CODE_W-1:0]             rx_code;
  logic [CODE_W-1:0]             tx_code_reg;
  logic [fcst_pkg::PERIOD_W-1:0] window_count;
  logic                          in_sweep;
  logic                          done_flag;
  logic                          accepted_flag;
  logic [CODE_W-1:0]             sweep_centre;
  logic [CODE_W-1:0]             saved_code;
  logic [SUM_W-1:0]              weighted_sum;
  logic [TOT_W-1:0]              frame_total;
  logic [fcst_pkg::FRAMES_W-1:0] frames;

  // Serial divider: remainder and quotient share one shift pair
  logic [TOT_W-1:0]  div_rem;
  logic [CODE_W-1:0] div_quo;
  logic [CNT_W-1:0]  div_cnt;

  fcst_pkg::ctrl_word_t  word;
  fcst_pkg::cond_flags_t flags;

  logic                          in_fire;
  logic                          out_free;
  logic [fcst_pkg::PERIOD_W-1:0] window_inc;
  logic                          trig;
  logic [CODE_W-1:0]             span_ext;
  logic [CODE_W-1:0]             centre_top;
  logic [CODE_W-1:0]             centre;
  logic [CODE_W-1:0]             sweep_start;
  logic [CODE_W:0]               hi_raw;
  logic [CODE_W-1:0]             hi;
  logic                          more;
  logic                          reject;
  logic [PROD_W-1:0]             prod;
  logic [TOT_W:0]                div_shift;
  logic [TOT_W:0]                div_trial;
  logic                          div_ge;
  logic signed [DIFF_W-1:0]      tx_move;
  logic [CODE_W-1:0]             tx_clamped;
  logic [CODE_W-1:0]             mean_limited;

  fcst_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .flags(flags),
    .word (word)
  );

  assign in_ready = (word.op == fcst_pkg::OP_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Window counter: the window that completes the count triggers, not joins, the sweep
  assign window_inc = window_count + fcst_pkg::PERIOD_W'(1);
  assign trig       = (window_inc >= calib_period);

  // Clamp the sweep centre so the span stays inside the code range
  assign span_ext   = CODE_W'(half_span);
  assign centre_top = CODE_TOP - span_ext;
  always_comb begin
    if (rx_code > centre_top) begin
      centre = centre_top;
    end else if (rx_code < span_ext) begin
      centre = span_ext;
    end else begin
      centre = rx_code;
    end
  end
  assign sweep_start = (centre >= span_ext) ? (centre - span_ext) : '0;

  // Last code of the sweep, with half_span as it stands now
  assign hi_raw = {1'b0, sweep_centre} + (CODE_W+1)'(half_span);
  assign hi     = (hi_raw > (CODE_W+1)'(CODE_MAX)) ? CODE_TOP : hi_raw[CODE_W-1:0];
  assign more   = (rx_code < hi);

  assign reject = (frame_total == '0) ||
                  (CMP_W'(frame_total) < CMP_W'(min_success));

  assign prod = {{CODE_W{1'b0}}, frames} * {{fcst_pkg::FRAMES_W{1'b0}}, rx_code};

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign div_shift = {div_rem, div_quo[CODE_W-1]};
  assign div_trial = div_shift - {1'b0, frame_total};
  assign div_ge    = (div_shift >= {1'b0, frame_total});

  // Move the transmit code by the same amount as the receive code, saturated
  assign tx_move = $signed({2'b00, tx_code_reg}) + $signed({2'b00, div_quo})
                 - $signed({2'b00, saved_code});
  always_comb begin
    if (tx_move < $signed(DIFF_W'(0))) begin
      tx_clamped = '0;
    end else if (tx_move > $signed(DIFF_W'(CODE_MAX))) begin
      tx_clamped = CODE_TOP;
    end else begin
      tx_clamped = tx_move[CODE_W-1:0];
    end
  end
  assign mean_limited = (div_quo > CODE_TOP) ? CODE_TOP : div_quo;

  always_comb begin
    flags.in_fire  = in_fire;
    flags.sweep    = in_sweep;
    flags.no_trig  = !trig;
    flags.more     = more;
    flags.reject   = reject;
    flags.div_more = (div_cnt != CNT_W'(CODE_W - 1));
    flags.out_free = out_free;
  end

  // Configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_period <= fcst_pkg::CALIB_PERIOD_RESET;
      min_success  <= fcst_pkg::MIN_SUCCESS_RESET;
      half_span    <= fcst_pkg::HALF_SPAN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        fcst_pkg::REG_CALIB_PERIOD: calib_period <= cfg_data[fcst_pkg::PERIOD_W-1:0];
        fcst_pkg::REG_MIN_SUCCESS:  min_success  <= cfg_data[fcst_pkg::MIN_W-1:0];
        fcst_pkg::REG_HALF_SPAN:    half_span    <= cfg_data[fcst_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state driven by the current control word
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_code       <= RX_INIT;
      tx_code_reg   <= TX_INIT;
      window_count  <= '0;
      in_sweep      <= 1'b0;
      done_flag     <= 1'b0;
      accepted_flag <= 1'b0;
      div_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      case (word.op)
        fcst_pkg::OP_LOAD: begin
          if (in_fire) begin
            done_flag     <= 1'b0;
            accepted_flag <= 1'b0;
          end
        end
        fcst_pkg::OP_COUNT: begin
          window_count <= trig ? '0 : window_inc;
        end
        fcst_pkg::OP_BEGIN: begin
          rx_code  <= sweep_start;
          in_sweep <= 1'b1;
        end
        fcst_pkg::OP_STEP: begin
          if (more) begin
            rx_code <= rx_code + CODE_W'(1);
          end
        end
        fcst_pkg::OP_END: begin
          in_sweep  <= 1'b0;
          done_flag <= 1'b1;
        end
        fcst_pkg::OP_DIV_LOAD: begin
          div_cnt <= '0;
        end
        fcst_pkg::OP_DIV_STEP: begin
          div_cnt <= div_cnt + CNT_W'(1);
        end
        fcst_pkg::OP_APPLY: begin
          rx_code       <= mean_limited;
          tx_code_reg   <= tx_clamped;
          accepted_flag <= 1'b1;
        end
        fcst_pkg::OP_RESTORE: begin
          rx_code <= saved_code;
        end
        fcst_pkg::OP_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
      // Drop the result once it has been taken, unless a new one lands now
      if (out_valid && out_ready && !(word.op == fcst_pkg::OP_EMIT)) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (word.op)
      fcst_pkg::OP_LOAD: begin
        if (in_fire) begin
          frames <= frames_received;
        end
      end
      fcst_pkg::OP_BEGIN: begin
        sweep_centre <= centre;
        saved_code   <= rx_code;
        weighted_sum <= '0;
        frame_total  <= '0;
      end
      fcst_pkg::OP_ACCUM: begin
        weighted_sum <= weighted_sum + SUM_W'(prod);
        frame_total  <= frame_total + TOT_W'(frames);
      end
      fcst_pkg::OP_DIV_LOAD: begin
        div_rem <= weighted_sum[SUM_W-1:CODE_W];
        div_quo <= weighted_sum[CODE_W-1:0];
      end
      fcst_pkg::OP_DIV_STEP: begin
        div_rem <= div_ge ? div_trial[TOT_W-1:0] : div_shift[TOT_W-1:0];
        div_quo <= {div_quo[CODE_W-2:0], div_ge};
      end
      fcst_pkg::OP_EMIT: begin
        if (out_free) begin
          rx_code_next   <= rx_code;
          tx_code        <= tx_code_reg;
          sweeping       <= in_sweep;
          sweep_done     <= done_flag;
          sweep_accepted <= accepted_flag;
        end
      end
      default: ;
    endcase
  end

endmodule
